### rtl/pdt_pkg.sv
// Shared types and constants for the prescaled down-counter timer bank.
// Used by pdt_ctrl, pdt_datapath and prescaled_downcounter_timer_bank.
package pdt_pkg;

    localparam int SLOTS_PER_BANK_DEF = 16;
    localparam int BANK_COUNT         = 4;
    localparam int CNT_W              = 32;
    localparam int FUNC_W             = 2;
    localparam int BANK_W             = 2;
    localparam int SLOT_IDX_W         = 4;

    localparam int REM_TEN_W      = 4;
    localparam int REM_HUNDRED_W  = 7;
    localparam int REM_THOUSAND_W = 10;

    localparam logic [REM_TEN_W-1:0]      DIV_TEN      = REM_TEN_W'(10);
    localparam logic [REM_HUNDRED_W-1:0]  DIV_HUNDRED  = REM_HUNDRED_W'(100);
    localparam logic [REM_THOUSAND_W-1:0] DIV_THOUSAND = REM_THOUSAND_W'(1000);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_SET   = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_RSVD  = 2'd3
    } func_t;

    typedef enum logic [BANK_W-1:0] {
        BANK_MS         = 2'd0,
        BANK_TEN_MS     = 2'd1,
        BANK_HUNDRED_MS = 2'd2,
        BANK_SECOND     = 2'd3
    } bank_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic sweep_rd;
        logic load_wr;
        logic slot_rd;
        logic out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_tick;
        logic is_set;
        logic sweep_last;
    } sts_t;

endpackage

### rtl/pdt_ctrl.sv
// Sequencing state machine for the timer bank: accept, slot sweep, set write, readback, output.
// Depends on pdt_pkg for the command and status structs.
module pdt_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    input  pdt_pkg::sts_t sts,
    output pdt_pkg::cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_FLUSH,
        ST_WRITE,
        ST_READ,
        ST_WAIT
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg, s_ready_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        cmd          = '0;
        cmd.accept   = s_valid && s_ready_reg;
        cmd.sweep_rd = (state_reg == ST_SWEEP);
        cmd.load_wr  = (state_reg == ST_WRITE);
        cmd.slot_rd  = (state_reg == ST_READ);
        cmd.out_load = (state_reg == ST_WAIT) && out_free;
    end

    always_comb begin
        state_next   = state_reg;
        s_ready_next = s_ready_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (cmd.accept) begin
                    s_ready_next = 1'b0;
                    if (sts.is_tick) begin
                        state_next = ST_SWEEP;
                    end else if (sts.is_set) begin
                        state_next = ST_WRITE;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_SWEEP: begin
                if (sts.sweep_last) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: state_next = ST_READ;
            ST_WRITE: state_next = ST_READ;
            ST_READ:  state_next = ST_WAIT;
            ST_WAIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    s_ready_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= s_ready_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = s_ready_reg;
    assign m_valid = m_valid_reg;

endmodule

### rtl/pdt_datapath.sv
// Datapath of the timer bank: tick counters, remainders, slot memory with valid bits,
// sweep address counters, decrement write-back and output word registers. Uses pdt_pkg.
module pdt_datapath #(
    parameter int SLOTS_PER_BANK = pdt_pkg::SLOTS_PER_BANK_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  pdt_pkg::cmd_t                     cmd,
    output pdt_pkg::sts_t                     sts,
    input  logic [pdt_pkg::FUNC_W-1:0]        s_func,
    input  logic [pdt_pkg::BANK_W-1:0]        s_bank,
    input  logic [pdt_pkg::SLOT_IDX_W-1:0]    s_slot_index,
    input  logic [pdt_pkg::CNT_W-1:0]         s_load_value,
    output logic [pdt_pkg::CNT_W-1:0]         m_slot_value,
    output logic [pdt_pkg::CNT_W-1:0]         m_ms_count,
    output logic [pdt_pkg::CNT_W-1:0]         m_ten_ms_count,
    output logic [pdt_pkg::CNT_W-1:0]         m_hundred_ms_count,
    output logic [pdt_pkg::CNT_W-1:0]         m_second_count
);

    localparam int DEPTH = pdt_pkg::BANK_COUNT * SLOTS_PER_BANK;
    localparam int AW    = $clog2(DEPTH);
    localparam int SLW   = (SLOTS_PER_BANK > 1) ? $clog2(SLOTS_PER_BANK) : 1;
    localparam int CW    = pdt_pkg::CNT_W;
    localparam int BW    = pdt_pkg::BANK_W;
    localparam int R1W   = pdt_pkg::REM_TEN_W;
    localparam int R2W   = pdt_pkg::REM_HUNDRED_W;
    localparam int R3W   = pdt_pkg::REM_THOUSAND_W;

    pdt_pkg::func_t     in_func;
    logic               in_slot_ok;
    logic [AW-1:0]      in_addr;

    logic [CW-1:0]  ms_reg, ms_next, ten_reg, ten_next;
    logic [CW-1:0]  hun_reg, hun_next, sec_reg, sec_next;
    logic [R1W-1:0] r1_reg, r1_next;
    logic [R2W-1:0] r2_reg, r2_next;
    logic [R3W-1:0] r3_reg, r3_next;
    logic [pdt_pkg::BANK_COUNT-1:0] fire_reg, fire_next;

    logic               slot_ok_reg;
    logic [AW-1:0]      addr_reg;
    logic [CW-1:0]      load_reg;

    logic [AW-1:0]      sw_addr_reg;
    logic [SLW-1:0]     sw_slot_reg;
    logic [BW-1:0]      sw_bank_reg;
    logic               wb_pend_reg;
    logic [AW-1:0]      wb_addr_reg;
    logic [BW-1:0]      wb_bank_reg;

    logic [CW-1:0]      mem_reg [DEPTH];
    logic [DEPTH-1:0]   vld_reg;
    logic [CW-1:0]      rdata_reg;
    logic               rvld_reg;
    logic [CW-1:0]      rd_word;

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [CW-1:0]      wr_data;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;

    logic [CW-1:0]  out_slot_reg, out_ms_reg, out_ten_reg, out_hun_reg, out_sec_reg;

    assign in_func    = pdt_pkg::func_t'(s_func);
    assign in_slot_ok = 32'(s_slot_index) < 32'(SLOTS_PER_BANK);
    assign in_addr    = in_slot_ok ? AW'(AW'(s_bank) * AW'(SLOTS_PER_BANK) + AW'(s_slot_index))
                                   : AW'(AW'(s_bank) * AW'(SLOTS_PER_BANK));

    assign sts.is_tick    = (in_func == pdt_pkg::FUNC_TICK);
    assign sts.is_set     = (in_func == pdt_pkg::FUNC_SET);
    assign sts.sweep_last = (sw_addr_reg == AW'(DEPTH - 1));

    // tick counters and remainders
    always_comb begin
        ms_next   = ms_reg;
        ten_next  = ten_reg;
        hun_next  = hun_reg;
        sec_next  = sec_reg;
        r1_next   = r1_reg;
        r2_next   = r2_reg;
        r3_next   = r3_reg;
        fire_next = fire_reg;
        if (cmd.accept) begin
            fire_next = '0;
            case (in_func)
                pdt_pkg::FUNC_TICK: begin
                    ms_next = ms_reg + CW'(1);
                    if (ms_next == '0) begin
                        r1_next = '0;
                        r2_next = '0;
                        r3_next = '0;
                    end else begin
                        r1_next = (r1_reg + R1W'(1) >= pdt_pkg::DIV_TEN) ? '0 : r1_reg + R1W'(1);
                        r2_next = (r2_reg + R2W'(1) >= pdt_pkg::DIV_HUNDRED) ? '0
                                                                            : r2_reg + R2W'(1);
                        r3_next = (r3_reg + R3W'(1) >= pdt_pkg::DIV_THOUSAND) ? '0
                                                                             : r3_reg + R3W'(1);
                    end
                    fire_next[pdt_pkg::BANK_MS] = 1'b1;
                    if (r1_next == '0) begin
                        ten_next = ten_reg + CW'(1);
                        fire_next[pdt_pkg::BANK_TEN_MS] = 1'b1;
                    end
                    if (r2_next == '0) begin
                        hun_next = hun_reg + CW'(1);
                        fire_next[pdt_pkg::BANK_HUNDRED_MS] = 1'b1;
                    end
                    if (r3_next == '0) begin
                        sec_next = sec_reg + CW'(1);
                        fire_next[pdt_pkg::BANK_SECOND] = 1'b1;
                    end
                end
                pdt_pkg::FUNC_CLEAR: begin
                    case (pdt_pkg::bank_t'(s_bank))
                        pdt_pkg::BANK_MS: begin
                            ms_next = '0;
                            r1_next = '0;
                            r2_next = '0;
                            r3_next = '0;
                        end
                        pdt_pkg::BANK_TEN_MS:     ten_next = '0;
                        pdt_pkg::BANK_HUNDRED_MS: hun_next = '0;
                        pdt_pkg::BANK_SECOND:     sec_next = '0;
                        default:                  ms_next  = ms_reg;
                    endcase
                end
                default: begin
                    ms_next = ms_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ms_reg   <= '0;
            ten_reg  <= '0;
            hun_reg  <= '0;
            sec_reg  <= '0;
            r1_reg   <= '0;
            r2_reg   <= '0;
            r3_reg   <= '0;
            fire_reg <= '0;
        end else begin
            ms_reg   <= ms_next;
            ten_reg  <= ten_next;
            hun_reg  <= hun_next;
            sec_reg  <= sec_next;
            r1_reg   <= r1_next;
            r2_reg   <= r2_next;
            r3_reg   <= r3_next;
            fire_reg <= fire_next;
        end
    end

    // item capture
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            slot_ok_reg <= in_slot_ok;
            addr_reg    <= in_addr;
            load_reg    <= s_load_value;
        end
    end

    // sweep address counters and write-back pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sw_addr_reg <= '0;
            sw_slot_reg <= '0;
            sw_bank_reg <= '0;
            wb_pend_reg <= 1'b0;
        end else begin
            wb_pend_reg <= cmd.sweep_rd;
            if (cmd.accept) begin
                sw_addr_reg <= '0;
                sw_slot_reg <= '0;
                sw_bank_reg <= '0;
            end else if (cmd.sweep_rd) begin
                sw_addr_reg <= sw_addr_reg + AW'(1);
                if (sw_slot_reg == SLW'(SLOTS_PER_BANK - 1)) begin
                    sw_slot_reg <= '0;
                    sw_bank_reg <= sw_bank_reg + BW'(1);
                end else begin
                    sw_slot_reg <= sw_slot_reg + SLW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        wb_addr_reg <= sw_addr_reg;
        wb_bank_reg <= sw_bank_reg;
    end

    // slot memory
    assign rd_word = rvld_reg ? rdata_reg : '0;
    assign wr_en   = (cmd.load_wr && slot_ok_reg) || (wb_pend_reg && fire_reg[wb_bank_reg]);
    assign wr_addr = cmd.load_wr ? addr_reg : wb_addr_reg;
    assign wr_data = cmd.load_wr ? load_reg : rd_word - CW'(rd_word != '0);
    assign rd_en   = cmd.sweep_rd || cmd.slot_rd;
    assign rd_addr = cmd.slot_rd ? addr_reg : sw_addr_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= mem_reg[rd_addr];
            rvld_reg  <= vld_reg[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (wr_en) begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    // output words
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_slot_reg <= slot_ok_reg ? rd_word : '0;
            out_ms_reg   <= ms_reg;
            out_ten_reg  <= ten_reg;
            out_hun_reg  <= hun_reg;
            out_sec_reg  <= sec_reg;
        end
    end

    assign m_slot_value       = out_slot_reg;
    assign m_ms_count         = out_ms_reg;
    assign m_ten_ms_count     = out_ten_reg;
    assign m_hundred_ms_count = out_hun_reg;
    assign m_second_count     = out_sec_reg;

endmodule

### rtl/prescaled_downcounter_timer_bank.sv
// Timer bank top level: four banks of SLOTS_PER_BANK down-counters plus decade tick counters.
// A tick word sweeps the slot memory one entry per cycle, then flushes, reads back and outputs;
// a set word writes, reads back and outputs; a clear or reserved word reads back and outputs.
// One word at a time: the next is taken once the last is in the output register, where it waits.
// Reset: aresetn synchronous, active low; clears counters and all slot valid bits at once.
// Depends on pdt_pkg, pdt_ctrl and pdt_datapath.
module prescaled_downcounter_timer_bank #(
    parameter int SLOTS_PER_BANK = pdt_pkg::SLOTS_PER_BANK_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [pdt_pkg::FUNC_W-1:0]        s_func,
    input  logic [pdt_pkg::BANK_W-1:0]        s_bank,
    input  logic [pdt_pkg::SLOT_IDX_W-1:0]    s_slot_index,
    input  logic [pdt_pkg::CNT_W-1:0]         s_load_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [pdt_pkg::CNT_W-1:0]         m_slot_value,
    output logic [pdt_pkg::CNT_W-1:0]         m_ms_count,
    output logic [pdt_pkg::CNT_W-1:0]         m_ten_ms_count,
    output logic [pdt_pkg::CNT_W-1:0]         m_hundred_ms_count,
    output logic [pdt_pkg::CNT_W-1:0]         m_second_count
);

    pdt_pkg::cmd_t cmd;
    pdt_pkg::sts_t sts;

    pdt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    pdt_datapath #(
        .SLOTS_PER_BANK (SLOTS_PER_BANK)
    ) u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .sts                (sts),
        .s_func             (s_func),
        .s_bank             (s_bank),
        .s_slot_index       (s_slot_index),
        .s_load_value       (s_load_value),
        .m_slot_value       (m_slot_value),
        .m_ms_count         (m_ms_count),
        .m_ten_ms_count     (m_ten_ms_count),
        .m_hundred_ms_count (m_hundred_ms_count),
        .m_second_count     (m_second_count)
    );

endmodule
